>>> rtl/krt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants of the keyed record table: field widths,
// operation and status codes, and the control word that drives the cells.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int KRT_DEPTH      = 32;
    localparam int KRT_LABEL_BITS = 64;

    localparam int KEY_BITS    = 16;
    localparam int SCORE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int OPCODE_BITS = 3;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_APPEND = 3'd0,
        OP_DUMP   = 3'd1,
        OP_SEARCH = 3'd2,
        OP_MODIFY = 3'd3,
        OP_DELETE = 3'd4
    } t_opcode;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd3;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic rotate;   // every cell takes its right neighbor's record
        logic compact;  // cells at or above the hit slot take their right neighbor
        logic append;   // the cell at the live count takes the new record
    } t_cell_ctl;

endpackage

>>> rtl/krt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_cell
// One slot of the record chain. Holds one record and loads either its right
// neighbor's record or a new record, as the broadcast control word says.
// ----------------------------------------------------------------------------
module krt_cell
    import krt_pkg::*;
#(
    parameter int DEPTH      = KRT_DEPTH,
    parameter int LABEL_BITS = KRT_LABEL_BITS,
    parameter int IDX        = 0,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int REC_W     = KEY_BITS + LABEL_BITS + SCORE_BITS
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_hit,
    input  logic [CNT_W-1:0] i_count,
    input  logic [REC_W-1:0] i_right,
    input  logic [REC_W-1:0] i_new,
    output logic [REC_W-1:0] o_rec
);

    logic [REC_W-1:0] r_rec;
    logic [REC_W-1:0] n_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.rotate) begin
            n_rec = i_right;
        end else if (i_ctl.compact && (IDX_W'(IDX) >= i_hit)) begin
            n_rec = i_right;
        end else if (i_ctl.append && (CNT_W'(IDX) == i_count)) begin
            n_rec = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

>>> rtl/keyed_record_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_core
// Packed table of keyed records with append, dump, search, modify and delete,
// built as a ring of record cells that is walked through its head cell.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and answers with one result
// word, or with one word per live record for a dump. Records sit in a chain
// of DEPTH cells in insertion order. Search, modify and delete rotate the
// whole ring once around, one slot per cycle, so every record passes the
// head cell once and the ring ends where it started; a command word of these
// kinds is answered from the finishing state, and a delete that hits adds the
// shift-down of the later records in the cycle that delivers the result.
// Append goes straight from idle to the finishing state. A dump delivers one
// word per live record while the ring turns and returns to idle once the
// ring has turned; the sink can stall it. Unused opcodes are dropped with no
// result. The result sits in an output register, so a finished word can wait
// on the sink while the next command is taken. Stored records have no reset;
// only the control registers, the live count among them, are cleared.
// ----------------------------------------------------------------------------
module keyed_record_table_core
    import krt_pkg::*;
#(
    parameter int DEPTH      = KRT_DEPTH,
    parameter int LABEL_BITS = KRT_LABEL_BITS,
    localparam int IN_W      = 2 * KEY_BITS + LABEL_BITS + SCORE_BITS,
    localparam int IN_TW     = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = STATUS_BITS + KEY_BITS + LABEL_BITS + SCORE_BITS,
    localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Command side.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata, low bit up: search_key, new_key, new_label, new_score, zero pad.
    input  logic [IN_TW-1:0]       i_s_tdata,
    // tuser: opcode.
    input  logic [OPCODE_BITS-1:0] i_s_tuser,
    // Result side.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata, low bit up: status, rec_key, rec_label, rec_score, zero pad.
    output logic [OUT_TW-1:0]      o_m_tdata,
    // tlast: last result word caused by the command.
    output logic                   o_m_tlast
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int REC_W = KEY_BITS + LABEL_BITS + SCORE_BITS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    // Control registers.
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_step, n_step;
    logic               r_found, n_found;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_m_valid, n_m_valid;

    // Payload registers.
    logic [OPCODE_BITS-1:0] r_op;
    logic [KEY_BITS-1:0]    r_skey;
    logic [REC_W-1:0]       r_new;
    logic [REC_W-1:0]       r_cap;
    logic [IDX_W-1:0]       r_hit;
    logic [OUT_W-1:0]       r_m_data;
    logic                   r_m_last;

    // Input fields.
    logic [KEY_BITS-1:0]   w_in_skey;
    logic [REC_W-1:0]      w_in_rec;

    assign w_in_skey = i_s_tdata[KEY_BITS-1:0];
    // Record layout: key in the low bits, then label, then score.
    assign w_in_rec  = i_s_tdata[IN_W-1:KEY_BITS];

    // Cell chain.
    logic [REC_W-1:0] w_rec [DEPTH];
    logic [REC_W-1:0] w_feed;
    logic [REC_W-1:0] w_head;
    t_cell_ctl        w_ctl;

    assign w_head = w_rec[0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [REC_W-1:0] w_right;
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_feed;
        end else begin : g_body
            assign w_right = w_rec[g + 1];
        end
        krt_cell #(
            .DEPTH      (DEPTH),
            .LABEL_BITS (LABEL_BITS),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_hit   (r_hit),
            .i_count (r_count),
            .i_right (w_right),
            .i_new   (r_new),
            .o_rec   (w_rec[g])
        );
    end

    // Scan step decode. The head cell holds slot r_step of the table.
    logic w_slot_free;
    logic w_live;
    logic w_match;
    logic w_last_step;
    logic w_full;
    logic w_emit;
    logic [STATUS_BITS-1:0] w_emit_status;
    logic [REC_W-1:0]       w_emit_rec;
    logic                   w_emit_last;
    logic                   w_accept;
    logic                   w_hit_set;
    logic                   w_cap_set;

    assign w_slot_free = !r_m_valid || i_m_tready;
    assign w_live      = CNT_W'(r_step) < r_count;
    assign w_match     = w_live && !r_found && (w_head[KEY_BITS-1:0] == r_skey);
    assign w_last_step = r_step == IDX_W'(DEPTH - 1);
    assign w_full      = r_count == CNT_W'(DEPTH);
    // No command word is taken while reset is held.
    assign o_s_tready  = i_rst_n && (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_found       = r_found;
        n_count       = r_count;
        n_m_valid     = r_m_valid && !i_m_tready;
        w_emit        = 1'b0;
        w_emit_status = ST_OK;
        w_emit_rec    = '0;
        w_emit_last   = 1'b1;
        w_ctl         = '0;
        w_feed        = w_head;
        w_hit_set     = 1'b0;
        w_cap_set     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_step  = '0;
                    n_found = 1'b0;
                    case (i_s_tuser)
                        OP_APPEND: n_state = S_FINISH;
                        OP_DUMP: begin
                            n_state = (r_count == '0) ? S_FINISH : S_SCAN;
                        end
                        OP_SEARCH, OP_MODIFY, OP_DELETE: n_state = S_SCAN;
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_SCAN: begin
                // A dump word for a live slot needs room in the output register.
                if (!(r_op == OP_DUMP && w_live) || w_slot_free) begin
                    w_ctl.rotate = 1'b1;
                    n_step       = r_step + IDX_W'(1);
                    if (r_op == OP_DUMP && w_live) begin
                        w_emit      = 1'b1;
                        w_emit_rec  = w_head;
                        w_emit_last = CNT_W'(r_step) == (r_count - CNT_W'(1));
                    end
                    if (w_match && r_op != OP_DUMP) begin
                        n_found = 1'b1;
                    end
                    if (w_match && r_op == OP_MODIFY) begin
                        w_feed = r_new;
                    end
                    w_hit_set = w_match && (r_op == OP_DELETE);
                    w_cap_set = w_match && (r_op == OP_SEARCH);
                    if (w_last_step) begin
                        n_step  = '0;
                        n_state = (r_op == OP_DUMP) ? S_IDLE : S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                if (w_slot_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    case (r_op)
                        OP_APPEND: begin
                            if (w_full) begin
                                w_emit_status = ST_FULL;
                            end else begin
                                w_ctl.append = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                            end
                        end
                        OP_DUMP: w_emit_status = ST_EMPTY;
                        OP_SEARCH: begin
                            w_emit_status = r_found ? ST_OK : ST_NOT_FOUND;
                            w_emit_rec    = r_found ? r_cap : '0;
                        end
                        OP_MODIFY: w_emit_status = r_found ? ST_OK : ST_NOT_FOUND;
                        OP_DELETE: begin
                            w_emit_status = r_found ? ST_OK : ST_NOT_FOUND;
                            if (r_found) begin
                                // Later records move down one slot behind the hit.
                                w_ctl.compact = 1'b1;
                                n_count       = r_count - CNT_W'(1);
                            end
                        end
                        default: w_emit = 1'b0;
                    endcase
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (w_emit) begin
            n_m_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_found   <= 1'b0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_found   <= n_found;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_s_tuser;
            r_skey <= w_in_skey;
            r_new  <= w_in_rec;
        end
        if (w_cap_set) begin
            r_cap <= w_head;
        end
        if (w_hit_set) begin
            r_hit <= r_step;
        end
        if (w_emit) begin
            r_m_data <= {w_emit_rec, w_emit_status};
            r_m_last <= w_emit_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_TW'(r_m_data);
    assign o_m_tlast  = r_m_last;

    // The live count never runs past the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("live count exceeds table depth");

    // Only the finishing step of a command may change the live count.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FINISH) |=> $stable(r_count))
        else $error("live count changed outside the finishing step");

    // An append on a full table leaves the table untouched.
    a_full_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_op == OP_APPEND && w_full) |=> $stable(r_count))
        else $error("append on a full table changed the live count");

    // Once the first match is seen it stays marked for the rest of the scan.
    a_found_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_found) |=> r_found)
        else $error("match flag dropped during a scan");

endmodule

>>> sim/tb_keyed_record_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_record_table_core
// Self-checking bench for the keyed record table over its stream ports.
// ----------------------------------------------------------------------------
// A local model of the table (its own key, label and score arrays and a live
// count) predicts every result word for each command word the block accepts.
// The run has three parts. A short list of hand-written commands covers the
// empty table, duplicate keys, keys and payloads at all-zero and all-ones,
// and unused opcodes. A fill pass takes the table to full, pushes one append
// past the end, and dumps all records. A random part mixes well-formed
// commands on a small key pool with arbitrary keys. Both sides idle at random.
// The sink also stops once for a long stretch so that the block backs up. The
// source also drains the block after each part and once in the random part.
// ----------------------------------------------------------------------------
module tb_keyed_record_table_core;
    import krt_pkg::*;

    localparam int IN_W   = 2 * KEY_BITS + KRT_LABEL_BITS + SCORE_BITS;
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = STATUS_BITS + KEY_BITS + KRT_LABEL_BITS + SCORE_BITS;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    // Result word bit positions, low bit up: status, key, label, score.
    localparam int KEY_LO   = STATUS_BITS;
    localparam int LABEL_LO = KEY_LO + KEY_BITS;
    localparam int SCORE_LO = LABEL_LO + KRT_LABEL_BITS;

    // Opcodes that the block must drop without a result.
    localparam logic [OPCODE_BITS-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OPCODE_BITS-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OPCODE_BITS-1:0] OP_UNUSED_7 = 3'd7;

    localparam int RANDOM_COMMANDS = 390;
    localparam int LONG_HOLD       = 400;

    typedef struct packed {
        logic [STATUS_BITS-1:0]    status;
        logic [KEY_BITS-1:0]       key;
        logic [KRT_LABEL_BITS-1:0] label;
        logic [SCORE_BITS-1:0]     score;
        logic                      last;
    } t_word;

    typedef struct packed {
        logic [OPCODE_BITS-1:0]    op;
        logic [KEY_BITS-1:0]       skey;
        logic [KEY_BITS-1:0]       nkey;
        logic [KRT_LABEL_BITS-1:0] label;
        logic [SCORE_BITS-1:0]     score;
        logic                      typed;  // status below is written by hand
        logic [STATUS_BITS-1:0]    st;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TW-1:0]       s_tdata;
    logic [OPCODE_BITS-1:0] s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TW-1:0]      m_tdata;
    logic                   m_tlast;

    keyed_record_table_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    // Model of the record table.
    logic [KEY_BITS-1:0]       key_mem   [KRT_DEPTH];
    logic [KRT_LABEL_BITS-1:0] label_mem [KRT_DEPTH];
    logic [SCORE_BITS-1:0]     score_mem [KRT_DEPTH];
    int                        live_records;

    t_word pending_words [$];
    t_row  plan [$];

    int fail_count;
    int words_checked;
    int op_count [8];
    int full_hits;
    int empty_hits;
    int miss_hits;

    // Idle control: calm turns off random idling on both sides, and a hold
    // request makes the sink stop for a long stretch.
    bit calm;
    bit hold_req;
    int hold_left;

    logic [KEY_BITS-1:0] key_pool [8];

    initial i_clk = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_word make_word(logic [STATUS_BITS-1:0] st,
                                        logic [KEY_BITS-1:0] k,
                                        logic [KRT_LABEL_BITS-1:0] l,
                                        logic [SCORE_BITS-1:0] s, logic lst);
        t_word w;
        w.status = st;
        w.key    = k;
        w.label  = l;
        w.score  = s;
        w.last   = lst;
        return w;
    endfunction

    // Applies one accepted command to the model and queues the words it
    // should produce. Only the first record with a matching key is used.
    task automatic apply_command(logic [OPCODE_BITS-1:0] op, logic [KEY_BITS-1:0] skey,
                                 logic [KEY_BITS-1:0] nkey,
                                 logic [KRT_LABEL_BITS-1:0] label,
                                 logic [SCORE_BITS-1:0] score);
        int hit;
        hit = -1;
        for (int i = 0; i < live_records; i++) begin
            if (hit < 0 && key_mem[i] == skey) hit = i;
        end
        op_count[op]++;
        case (op)
            OP_APPEND: begin
                if (live_records >= KRT_DEPTH) begin
                    full_hits++;
                    pending_words.push_back(make_word(ST_FULL, '0, '0, '0, 1'b1));
                end else begin
                    key_mem[live_records]   = nkey;
                    label_mem[live_records] = label;
                    score_mem[live_records] = score;
                    live_records++;
                    pending_words.push_back(make_word(ST_OK, '0, '0, '0, 1'b1));
                end
            end
            OP_DUMP: begin
                if (live_records == 0) begin
                    empty_hits++;
                    pending_words.push_back(make_word(ST_EMPTY, '0, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < live_records; i++) begin
                        pending_words.push_back(make_word(ST_OK, key_mem[i], label_mem[i],
                                                          score_mem[i],
                                                          i == live_records - 1));
                    end
                end
            end
            OP_SEARCH, OP_MODIFY, OP_DELETE: begin
                if (hit < 0) begin
                    miss_hits++;
                    pending_words.push_back(make_word(ST_NOT_FOUND, '0, '0, '0, 1'b1));
                end else if (op == OP_SEARCH) begin
                    pending_words.push_back(make_word(ST_OK, key_mem[hit], label_mem[hit],
                                                      score_mem[hit], 1'b1));
                end else begin
                    if (op == OP_MODIFY) begin
                        key_mem[hit]   = nkey;
                        label_mem[hit] = label;
                        score_mem[hit] = score;
                    end else begin
                        // Close the gap: every later record moves down one slot.
                        for (int i = hit; i + 1 < live_records; i++) begin
                            key_mem[i]   = key_mem[i + 1];
                            label_mem[i] = label_mem[i + 1];
                            score_mem[i] = score_mem[i + 1];
                        end
                        live_records--;
                    end
                    pending_words.push_back(make_word(ST_OK, '0, '0, '0, 1'b1));
                end
            end
            default: ;
        endcase
    endtask

    // Offers one command word, waits for the handshake and then records what
    // the block should answer. The ready line is looked at on the falling
    // edge, where it is settled, and the word moves on the next rising edge.
    task automatic send_command(t_row r);
        bit taken;
        int queued;
        if (!calm) begin
            while ($urandom_range(0, 99) < 11) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {r.score, r.label, r.nkey, r.skey};
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_tready;
            @(posedge i_clk);
        end
        queued = pending_words.size();
        apply_command(r.op, r.skey, r.nkey, r.label, r.score);
        if (r.typed) begin
            // The hand-written status replaces the model's answer.
            while (pending_words.size() > queued) void'(pending_words.pop_back());
            pending_words.push_back(make_word(r.st, '0, '0, '0, 1'b1));
        end
    endtask

    // Stops offering commands until every expected word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    function automatic t_row random_row(logic [OPCODE_BITS-1:0] op);
        t_row r;
        r.op    = op;
        r.typed = 1'b0;
        r.st    = ST_OK;
        r.nkey  = ($urandom_range(0, 99) < 65) ? key_pool[$urandom_range(0, 7)]
                                               : KEY_BITS'($urandom_range(0, 65535));
        // Mostly aim at a stored key so that hits are common.
        if (live_records > 0 && $urandom_range(0, 99) < 70)
            r.skey = key_mem[$urandom_range(0, live_records - 1)];
        else if ($urandom_range(0, 99) < 50)
            r.skey = key_pool[$urandom_range(0, 7)];
        else
            r.skey = KEY_BITS'($urandom_range(0, 65535));
        r.label = {$urandom(), $urandom()};
        r.score = $urandom();
        return r;
    endfunction

    function automatic logic [OPCODE_BITS-1:0] random_op();
        int append_pct;
        int pick;
        append_pct = (live_records >= KRT_DEPTH - 2) ? 15 : (live_records < 6 ? 55 : 32);
        if ($urandom_range(0, 99) < append_pct) return OP_APPEND;
        pick = $urandom_range(0, 99);
        if (pick < 12) return OP_DUMP;
        if (pick < 45) return OP_SEARCH;
        if (pick < 65) return OP_MODIFY;
        if (pick < 95) return OP_DELETE;
        return OPCODE_BITS'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
    endfunction

    // Result checker. Words are taken on the falling edge before the rising
    // edge that completes the handshake; nothing on either side moves between.
    always @(negedge i_clk) begin
        t_word got;
        t_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = make_word(m_tdata[KEY_LO-1:0], m_tdata[LABEL_LO-1:KEY_LO],
                            m_tdata[SCORE_LO-1:LABEL_LO],
                            m_tdata[SCORE_LO+SCORE_BITS-1:SCORE_LO], m_tlast);
            words_checked++;
            if (pending_words.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result word with nothing pending: status %0d key %h",
                             $realtime, got.status, got.key);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: word mismatch, expected st %0d key %h label %h score %h last %b",
                                 $realtime, want.status, want.key, want.label, want.score,
                                 want.last);
                        $display("%0t:                  actual st %0d key %h label %h score %h last %b",
                                 $realtime, got.status, got.key, got.label, got.score,
                                 got.last);
                    end
                end
            end
        end
    end

    // Sink: random idling, plus one long stop on request.
    initial begin
        m_tready = 1'b0;
        hold_left = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 11);
            end
            @(posedge i_clk);
        end
    end

    // Watchdog on the whole run.
    initial begin
        #10ms;
        $display("watchdog expired with %0d words still pending", pending_words.size());
        $display("[keyed_record_table_core] ERROR");
        $finish;
    end

    initial begin
        t_row r;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        live_records  = 0;
        fail_count    = 0;
        words_checked = 0;
        full_hits     = 0;
        empty_hits    = 0;
        miss_hits     = 0;
        foreach (op_count[i]) op_count[i] = 0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++) key_pool[i] = KEY_BITS'($urandom_range(0, 65535));

        // Hand-written commands. Rows with typed set carry their status here;
        // the others are answered by the model.
        plan.push_back('{OP_DUMP,     16'h0000, 16'h0000, 64'h0, 32'h0, 1'b1, ST_EMPTY});
        plan.push_back('{OP_SEARCH,   16'h0000, 16'h0000, 64'h0, 32'h0, 1'b1, ST_NOT_FOUND});
        plan.push_back('{OP_MODIFY,   16'hFFFF, 16'hFFFF, '1, '1, 1'b1, ST_NOT_FOUND});
        plan.push_back('{OP_DELETE,   16'h0000, 16'h0000, 64'h0, 32'h0, 1'b1, ST_NOT_FOUND});
        plan.push_back('{OP_UNUSED_5, 16'h0000, 16'h0000, 64'h0, 32'h0, 1'b0, ST_OK});
        plan.push_back('{OP_APPEND,   16'h1234, 16'h0000, 64'h0, 32'h0, 1'b1, ST_OK});
        plan.push_back('{OP_APPEND,   16'h0000, 16'hFFFF, '1, '1, 1'b1, ST_OK});
        plan.push_back('{OP_APPEND,   16'hFFFF, 16'hFFFF, 64'h5555_5555_5555_5555,
                         32'hAAAA_AAAA, 1'b1, ST_OK});
        plan.push_back('{OP_SEARCH,   16'hFFFF, 16'h0000, 64'h0, 32'h0, 1'b0, ST_OK});
        plan.push_back('{OP_SEARCH,   16'h0000, 16'hFFFF, '1, '1, 1'b0, ST_OK});
        plan.push_back('{OP_MODIFY,   16'hFFFF, 16'h00A5, 64'h0123_4567_89AB_CDEF,
                         32'hDEAD_BEEF, 1'b1, ST_OK});
        plan.push_back('{OP_SEARCH,   16'hFFFF, 16'h0000, 64'h0, 32'h0, 1'b0, ST_OK});
        plan.push_back('{OP_SEARCH,   16'h00A5, 16'h0000, 64'h0, 32'h0, 1'b0, ST_OK});
        plan.push_back('{OP_DUMP,     16'h0000, 16'h0000, 64'h0, 32'h0, 1'b0, ST_OK});
        plan.push_back('{OP_DELETE,   16'h0000, 16'h0000, 64'h0, 32'h0, 1'b1, ST_OK});
        plan.push_back('{OP_DELETE,   16'h1234, 16'h0000, 64'h0, 32'h0, 1'b1, ST_NOT_FOUND});
        plan.push_back('{OP_UNUSED_6, 16'h5A5A, 16'hA5A5, 64'h0, 32'h0, 1'b0, ST_OK});
        plan.push_back('{OP_UNUSED_7, 16'hFFFF, 16'hFFFF, '1, '1, 1'b0, ST_OK});
        plan.push_back('{OP_MODIFY,   16'h00A5, 16'hFFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                         32'h5555_5555, 1'b1, ST_OK});
        plan.push_back('{OP_DUMP,     16'h0000, 16'h0000, 64'h0, 32'h0, 1'b0, ST_OK});
        plan.push_back('{OP_DELETE,   16'hFFFF, 16'h0000, 64'h0, 32'h0, 1'b1, ST_OK});
        plan.push_back('{OP_SEARCH,   16'hFFFF, 16'h0000, 64'h0, 32'h0, 1'b0, ST_OK});
        plan.push_back('{OP_DUMP,     16'h0000, 16'h0000, 64'h0, 32'h0, 1'b0, ST_OK});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) send_command(plan[i]);
        wait_drained();

        // Fill the table, go one past the end, then read it all back and
        // work on both ends of a full table.
        while (live_records < KRT_DEPTH) send_command(random_row(OP_APPEND));
        r = random_row(OP_APPEND);
        r.typed = 1'b1;
        r.st    = ST_FULL;
        send_command(r);
        send_command(random_row(OP_DUMP));
        r = random_row(OP_DELETE);
        r.skey = key_mem[KRT_DEPTH - 1];
        send_command(r);
        send_command(random_row(OP_APPEND));
        r = random_row(OP_SEARCH);
        r.skey = key_mem[KRT_DEPTH - 1];
        send_command(r);
        r = random_row(OP_DELETE);
        r.skey = key_mem[0];
        send_command(r);
        wait_drained();

        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            // The sink stops for a long while here and the source keeps going,
            // so the block fills up and holds off new commands.
            if (n == 100) hold_req = 1'b1;
            calm = (n >= 250 && n < 330);
            if (n == 380) wait_drained();
            send_command(random_row(random_op()));
        end
        calm = 1'b0;

        wait_drained();
        // Give the block time to show any stray word after the last one.
        repeat (2 * KRT_DEPTH + 8) @(posedge i_clk);

        $display("commands: %0d append, %0d dump, %0d search, %0d modify, %0d delete, %0d unused",
                 op_count[OP_APPEND], op_count[OP_DUMP], op_count[OP_SEARCH],
                 op_count[OP_MODIFY], op_count[OP_DELETE],
                 op_count[5] + op_count[6] + op_count[7]);
        $display("%0d result words checked; %0d full, %0d empty, %0d key misses, %0d mismatches",
                 words_checked, full_hits, empty_hits, miss_hits, fail_count);
        if (fail_count == 0) begin
            $display("[keyed_record_table_core] OK");
        end else begin
            $display("[keyed_record_table_core] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/krt_pkg.sv
rtl/krt_cell.sv
rtl/keyed_record_table_core.sv
sim/tb_keyed_record_table_core.sv
